>>> design/btcq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btcq_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic valid;
    logic hit;
  } chain_tok_t;

endpackage

`default_nettype wire

>>> design/btcq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module btcq_cell import btcq_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic signed [W-1:0] wr_cx,
  input  wire logic signed [W-1:0] wr_by,
  input  wire logic signed [W-1:0] wr_cz,
  input  wire logic        [W-2:0] wr_ex,
  input  wire logic        [W-2:0] wr_ey,
  input  wire logic        [W-2:0] wr_ez,
  input  wire logic                active,
  input  wire logic signed [W+1:0] q_xl,
  input  wire logic signed [W+1:0] q_xh,
  input  wire logic signed [W+1:0] q_zl,
  input  wire logic signed [W+1:0] q_zh,
  input  wire logic signed [W-1:0] q_y,
  input  wire chain_tok_t          tok_in,
  output chain_tok_t               tok_out
);

  logic signed [W-1:0] cx;
  logic signed [W-1:0] by;
  logic signed [W-1:0] cz;
  logic        [W-2:0] ex;
  logic        [W-2:0] ey;
  logic        [W-2:0] ez;

  logic signed [W+1:0] x_lo;
  logic signed [W+1:0] x_hi;
  logic signed [W+1:0] z_lo;
  logic signed [W+1:0] z_hi;
  logic signed [W:0]   y_top;
  logic                match;
  chain_tok_t          tok_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cx <= wr_cx;
      by <= wr_by;
      cz <= wr_cz;
      ex <= wr_ex;
      ey <= wr_ey;
      ez <= wr_ez;
    end
  end

  // x and z bounds at doubled scale so half extents stay exact
  always_comb begin
    x_lo  = $signed({cx[W-1], cx, 1'b0}) - $signed({3'b000, ex});
    x_hi  = $signed({cx[W-1], cx, 1'b0}) + $signed({3'b000, ex});
    z_lo  = $signed({cz[W-1], cz, 1'b0}) - $signed({3'b000, ez});
    z_hi  = $signed({cz[W-1], cz, 1'b0}) + $signed({3'b000, ez});
    y_top = $signed({by[W-1], by}) + $signed({2'b00, ey});
    match = (q_xh > x_lo) && (q_xl < x_hi) &&
            (q_y > by) && ($signed({q_y[W-1], q_y}) < y_top) &&
            (q_zh > z_lo) && (q_zl < z_hi);
    tok_next.valid = tok_in.valid;
    tok_next.hit   = tok_in.hit | (tok_in.valid & active & match);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

>>> design/box_table_collision_query_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Box table with collision query.
// Command channel: an item transfers at a rising edge with start high and
// busy low. command selects insert (append box), clear (empty the table)
// or query (test pos/radius against every stored box, and pos_y - height
// against ground_height). Config: cfg_we/cfg_wdata write ground_height.
// Result channel: done pulses for one cycle with wall_hit, ground_hit and
// status; the receiver cannot stall it. status flags an insert dropped
// because the table already holds MAX_BOXES boxes.
// Insert, clear and unused commands give done in the cycle after the
// transfer and busy stays low, so they can follow every cycle.
// A query walks a token through a chain of MAX_BOXES cells, one cell
// per cycle, each cell holding one box; the launch register, the cells
// and the done register lie between the transfer and done. busy stays
// high until done rises, so the next command waits for the result.
// Reset empties the table (count to zero), sets ground_height to zero and
// drops any query in flight. Box contents are not cleared.

module box_table_collision_query_top import btcq_pkg::*; #(
  parameter int MAX_BOXES   = 64,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z,
  input  wire logic        [COORD_WIDTH-2:0] size_x,
  input  wire logic        [COORD_WIDTH-2:0] size_y,
  input  wire logic        [COORD_WIDTH-2:0] size_z,
  input  wire logic        [COORD_WIDTH-2:0] radius,
  input  wire logic signed [COORD_WIDTH-1:0] height,
  input  wire logic                          cfg_we,
  input  wire logic signed [COORD_WIDTH-1:0] cfg_wdata,
  output logic                               done,
  output logic                               wall_hit,
  output logic                               ground_hit,
  output logic                               status
);

  localparam int W     = COORD_WIDTH;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_QUERY = 1'b1;

  logic                state;
  logic [CNT_W-1:0]    count;
  logic signed [W-1:0] ground_height;
  logic signed [W+1:0] q_xl;
  logic signed [W+1:0] q_xh;
  logic signed [W+1:0] q_zl;
  logic signed [W+1:0] q_zh;
  logic signed [W-1:0] q_y;
  logic                gnd_pend;
  logic                launch;

  logic                accept;
  logic                full;
  logic signed [W:0]   bottom;
  chain_tok_t          tok [0:MAX_BOXES];
  logic [MAX_BOXES-1:0] chain_valid;

  assign busy   = (state == S_QUERY);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(MAX_BOXES));
  assign bottom = $signed({pos_y[W-1], pos_y}) - $signed({height[W-1], height});

  assign tok[0].valid = launch;
  assign tok[0].hit   = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_BOXES; gi++) begin : g_cell
      btcq_cell #(.W(W)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .wr_en   (accept && command == CMD_INSERT && count == CNT_W'(gi)),
        .wr_cx   (pos_x),
        .wr_by   (pos_y),
        .wr_cz   (pos_z),
        .wr_ex   (size_x),
        .wr_ey   (size_y),
        .wr_ez   (size_z),
        .active  (count > CNT_W'(gi)),
        .q_xl    (q_xl),
        .q_xh    (q_xh),
        .q_zl    (q_zl),
        .q_zh    (q_zh),
        .q_y     (q_y),
        .tok_in  (tok[gi]),
        .tok_out (tok[gi+1])
      );
      assign chain_valid[gi] = tok[gi+1].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_height <= '0;
    end else if (cfg_we) begin
      ground_height <= cfg_wdata;
    end
    if (accept && command == CMD_QUERY) begin
      q_xl     <= ($signed({{2{pos_x[W-1]}}, pos_x}) - $signed({3'b000, radius})) <<< 1;
      q_xh     <= ($signed({{2{pos_x[W-1]}}, pos_x}) + $signed({3'b000, radius})) <<< 1;
      q_zl     <= ($signed({{2{pos_z[W-1]}}, pos_z}) - $signed({3'b000, radius})) <<< 1;
      q_zh     <= ($signed({{2{pos_z[W-1]}}, pos_z}) + $signed({3'b000, radius})) <<< 1;
      q_y      <= pos_y;
      gnd_pend <= (bottom <= $signed({ground_height[W-1], ground_height}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      launch     <= 1'b0;
      done       <= 1'b0;
      wall_hit   <= 1'b0;
      ground_hit <= 1'b0;
      status     <= 1'b0;
    end else begin
      launch     <= 1'b0;
      done       <= 1'b0;
      wall_hit   <= 1'b0;
      ground_hit <= 1'b0;
      status     <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (command)
              CMD_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  status <= 1'b1;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              CMD_CLEAR: begin
                done  <= 1'b1;
                count <= '0;
              end
              CMD_QUERY: begin
                launch <= 1'b1;
                state  <= S_QUERY;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_QUERY: begin
          if (tok[MAX_BOXES].valid) begin
            done       <= 1'b1;
            wall_hit   <= tok[MAX_BOXES].hit;
            ground_hit <= gnd_pend;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_QUERY |=> busy)
    else $error("query transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while query in flight");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({launch, chain_valid}))
    else $error("more than one query token in chain");

  a_chain_end: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_BOXES].valid |=> done)
    else $error("token left chain without a result");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_INSERT && !full |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance box count");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import btcq_pkg::*;

  localparam int MAX_BOXES    = 64;
  localparam int CW           = 32;
  localparam int TARGET_ITEMS = 1700;
  localparam int NUM_PHASES   = 4;
  localparam int MAX_GAP      = 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [CW-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [CW-1:0] Q_TWO  = 32'sh0002_0000;
  localparam logic signed [CW-1:0] Q_FOUR = 32'sh0004_0000;
  localparam logic signed [CW-1:0] C_MAX  = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] C_MIN  = 32'sh8000_0000;
  localparam logic        [CW-2:0] E_MAX  = 31'h7fff_ffff;
  localparam logic        [CW-2:0] E_TWO  = 31'h0002_0000;

  typedef struct packed {
    logic [1:0]           command;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic [CW-2:0]        size_x;
    logic [CW-2:0]        size_y;
    logic [CW-2:0]        size_z;
    logic [CW-2:0]        radius;
    logic signed [CW-1:0] height;
  } box_cmd_t;

  typedef struct packed {
    logic wall_hit;
    logic ground_hit;
    logic status;
  } response_t;

  typedef struct packed {
    box_cmd_t  cmd;
    logic      typed;
    response_t fixed_resp;
  } directed_row_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic [1:0]           command   = CMD_INSERT;
  logic signed [CW-1:0] pos_x     = '0;
  logic signed [CW-1:0] pos_y     = '0;
  logic signed [CW-1:0] pos_z     = '0;
  logic [CW-2:0]        size_x    = '0;
  logic [CW-2:0]        size_y    = '0;
  logic [CW-2:0]        size_z    = '0;
  logic [CW-2:0]        radius    = '0;
  logic signed [CW-1:0] height    = '0;
  logic                 cfg_we    = 1'b0;
  logic signed [CW-1:0] cfg_wdata = '0;
  logic                 busy;
  logic                 done;
  logic                 wall_hit;
  logic                 ground_hit;
  logic                 status;

  // predictor state
  longint box_cx [MAX_BOXES];
  longint box_by [MAX_BOXES];
  longint box_cz [MAX_BOXES];
  longint box_ex [MAX_BOXES];
  longint box_ey [MAX_BOXES];
  longint box_ez [MAX_BOXES];
  int     box_total    = 0;
  longint ground_level = 0;

  response_t pending_responses [$];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        stall_cycles = 0;
  int        items_sent   = 0;
  int        idle_pct     = 0;
  int        scene_idle   = 0;

  box_table_collision_query_top #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_WIDTH(CW)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .size_x    (size_x),
    .size_y    (size_y),
    .size_z    (size_z),
    .radius    (radius),
    .height    (height),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .wall_hit  (wall_hit),
    .ground_hit(ground_hit),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic response_t box_table_response(input box_cmd_t it);
    response_t r;
    longint px, py, pz, rad, h, xl, xh, zl, zh;
    r   = '0;
    px  = longint'($signed(it.pos_x));
    py  = longint'($signed(it.pos_y));
    pz  = longint'($signed(it.pos_z));
    rad = longint'($unsigned(it.radius));
    h   = longint'($signed(it.height));
    case (it.command)
      CMD_INSERT: begin
        if (box_total < MAX_BOXES) begin
          box_cx[box_total] = px;
          box_by[box_total] = py;
          box_cz[box_total] = pz;
          box_ex[box_total] = longint'($unsigned(it.size_x));
          box_ey[box_total] = longint'($unsigned(it.size_y));
          box_ez[box_total] = longint'($unsigned(it.size_z));
          box_total++;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_CLEAR: begin
        box_total = 0;
      end
      CMD_QUERY: begin
        // x/z compares at doubled scale so half extents stay exact
        xl = 2 * (px - rad);
        xh = 2 * (px + rad);
        zl = 2 * (pz - rad);
        zh = 2 * (pz + rad);
        for (int i = 0; i < box_total; i++) begin
          if (xh > 2 * box_cx[i] - box_ex[i] && xl < 2 * box_cx[i] + box_ex[i] &&
              py > box_by[i] && py < box_by[i] + box_ey[i] &&
              zh > 2 * box_cz[i] - box_ez[i] && zl < 2 * box_cz[i] + box_ez[i])
            r.wall_hit = 1'b1;
        end
        r.ground_hit = (py - h <= ground_level);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic directed_row_t make_row(
    input logic [1:0]           cmd,
    input logic signed [CW-1:0] px, py, pz,
    input logic [CW-2:0]        sx, sy, sz, rad,
    input logic signed [CW-1:0] h,
    input logic                 typed, w, g, s
  );
    directed_row_t row;
    row.cmd        = '{cmd, px, py, pz, sx, sy, sz, rad, h};
    row.typed      = typed;
    row.fixed_resp = '{w, g, s};
    return row;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = C_MAX;
          1:       v = C_MIN;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      default: v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
    return v;
  endfunction

  function automatic logic [CW-2:0] rand_extent();
    logic [CW-2:0] v;
    case ($urandom_range(0, 9))
      0:       v = (CW-1)'($urandom);
      1:       v = (CW-1)'($urandom_range(0, 2));
      default: v = (CW-1)'($urandom_range(0, 32'h0008_0000));
    endcase
    return v;
  endfunction

  function automatic box_cmd_t random_item(input logic [1:0] cmd);
    box_cmd_t it;
    it.command = cmd;
    it.pos_x   = rand_coord();
    it.pos_y   = rand_coord();
    it.pos_z   = rand_coord();
    it.size_x  = rand_extent();
    it.size_y  = rand_extent();
    it.size_z  = rand_extent();
    it.radius  = rand_extent();
    it.height  = rand_coord();
    return it;
  endfunction

  // query placed inside or right on the border of a stored box
  function automatic box_cmd_t aimed_query();
    box_cmd_t    q;
    int          k;
    bit          on_border;
    int unsigned rr;
    longint      ox, oy, oz;
    q = random_item(CMD_QUERY);
    if (box_total == 0)
      return q;
    k         = $urandom_range(0, box_total - 1);
    on_border = ($urandom_range(0, 3) == 0);
    rr        = on_border ? $urandom_range(0, 1) : $urandom_range(0, 32'h0002_0000);
    if (on_border) begin
      ox = (($urandom_range(0, 1) != 0) ? 1 : -1) * (box_ex[k] / 2 + rr)
           + longint'($urandom_range(0, 2)) - 1;
      oz = (($urandom_range(0, 1) != 0) ? 1 : -1) * (box_ez[k] / 2 + rr)
           + longint'($urandom_range(0, 2)) - 1;
      oy = (($urandom_range(0, 1) != 0) ? box_ey[k] : 0)
           + longint'($urandom_range(0, 2)) - 1;
    end else begin
      ox = longint'($urandom_range(0, int'(box_ex[k]))) - box_ex[k] / 2;
      oz = longint'($urandom_range(0, int'(box_ez[k]))) - box_ez[k] / 2;
      oy = longint'($urandom_range(0, int'(box_ey[k])));
    end
    q.pos_x  = CW'(box_cx[k] + ox);
    q.pos_y  = CW'(box_by[k] + oy);
    q.pos_z  = CW'(box_cz[k] + oz);
    q.radius = (CW-1)'(rr);
    return q;
  endfunction

  task automatic transfer(input box_cmd_t it, input logic typed = 1'b0,
                          input response_t fixed_resp = '0);
    int        gap;
    response_t predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < scene_idle)
      gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= it.command;
    pos_x   <= it.pos_x;
    pos_y   <= it.pos_y;
    pos_z   <= it.pos_z;
    size_x  <= it.size_x;
    size_y  <= it.size_y;
    size_z  <= it.size_z;
    radius  <= it.radius;
    height  <= it.height;
    do @(posedge clk); while (busy);
    predicted = box_table_response(it);
    pending_responses.insert(pending_responses.size(), typed ? fixed_resp : predicted);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic write_ground(input logic signed [CW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    ground_level = longint'(v);
  endtask

  task automatic run_scene();
    int kind;
    int n_ins;
    int n_qry;
    kind       = $urandom_range(0, 39);
    scene_idle = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
    if ($urandom_range(0, 29) == 0)
      drain();
    if (kind < 4) begin
      // noise: any command, any fields
      repeat ($urandom_range(3, 10))
        transfer(random_item(2'($urandom_range(0, 3))));
    end else if (kind == 4) begin
      // fill the table, overflow it, then query it
      if ($urandom_range(0, 1) == 0)
        transfer(random_item(CMD_CLEAR));
      while (box_total < MAX_BOXES)
        transfer(random_item(CMD_INSERT));
      repeat ($urandom_range(1, 3))
        transfer(random_item(CMD_INSERT));
      repeat (2)
        transfer(aimed_query());
    end else begin
      if ($urandom_range(0, 2) == 0)
        transfer(random_item(CMD_CLEAR));
      n_ins = $urandom_range(0, 6);
      n_qry = $urandom_range(1, 4);
      while (n_ins + n_qry > 0) begin
        if (n_ins > 0 && (n_qry == 0 || $urandom_range(0, 1) == 0)) begin
          transfer(random_item(CMD_INSERT));
          n_ins--;
        end else begin
          transfer(($urandom_range(0, 3) == 0) ? random_item(CMD_QUERY) : aimed_query());
          n_qry--;
        end
      end
    end
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: result %0d: %s", $time, results_seen, msg);
  endtask

  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= ((start && !busy) || done) ? 0 : stall_cycles + 1;
      if (done) begin
        if (pending_responses.size() == 0) begin
          flag_error($sformatf("unexpected transfer: wall_hit=%0b ground_hit=%0b status=%0b",
                               wall_hit, ground_hit, status));
        end else begin
          want = pending_responses.pop_front();
          if (wall_hit !== want.wall_hit)
            flag_error($sformatf("wall_hit exp %0b got %0b", want.wall_hit, wall_hit));
          if (ground_hit !== want.ground_hit)
            flag_error($sformatf("ground_hit exp %0b got %0b", want.ground_hit, ground_hit));
          if (status !== want.status)
            flag_error($sformatf("status exp %0b got %0b", want.status, status));
        end
        results_seen++;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    directed_row_t directed_rows [22];
    int            phase_end;
    directed_rows = '{
      make_row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b1, 1'b0),
      make_row(CMD_QUERY, C_MAX, C_MAX, C_MIN, 0, 0, 0, E_MAX, C_MIN,
               1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, C_MIN, C_MIN, C_MAX, E_MAX, E_MAX, E_MAX, 0, C_MAX,
               1'b1, 1'b0, 1'b1, 1'b0),
      make_row(CMD_UNUSED, -1, -1, -1, E_MAX, E_MAX, E_MAX, E_MAX, -1,
               1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_INSERT, 0, 0, 0, E_TWO, E_TWO, E_TWO, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0, 1'b0),
      make_row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b1, 1'b0),
      make_row(CMD_QUERY, 0, Q_TWO, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, Q_ONE, Q_ONE, 0, 0, 0, 0, 1, 0, 1'b0, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, 0, Q_ONE, -Q_ONE, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_INSERT, C_MAX, C_MIN, C_MIN, E_MAX, E_MAX, E_MAX, 0, 0,
               1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, C_MAX, C_MIN + 1, C_MIN, 0, 0, 0, E_MAX, 0,
               1'b0, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, C_MIN, -1, C_MAX, 0, 0, 0, E_MAX, C_MIN,
               1'b0, 1'b0, 1'b0, 1'b0),
      make_row(CMD_CLEAR, C_MAX, C_MAX, C_MAX, E_MAX, E_MAX, E_MAX, E_MAX, C_MAX,
               1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_INSERT, Q_FOUR, 0, Q_FOUR, 1, E_MAX, 1, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, Q_FOUR, 5, Q_FOUR, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, Q_FOUR + 1, 5, Q_FOUR, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0),
      make_row(CMD_INSERT, 0, 0, 0, E_TWO, 0, E_TWO, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0),
      make_row(CMD_QUERY, C_MAX, C_MAX, 0, 0, 0, 0, 0, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0),
      make_row(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    scene_idle = 30;
    foreach (directed_rows[i])
      transfer(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].fixed_resp);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0:       write_ground(C_MAX);
        1:       write_ground(C_MIN);
        2:       write_ground($urandom);
        default: write_ground(rand_coord());
      endcase
      case (phase)
        1:       idle_pct = 73;
        2:       idle_pct = 14;
        default: idle_pct = 0;
      endcase
      phase_end = items_sent + TARGET_ITEMS / NUM_PHASES;
      while (items_sent < phase_end)
        run_scene();
    end

    drain();
    repeat (MAX_BOXES + 4) @(posedge clk);
    if (mismatches == 0 && pending_responses.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
